// ----- src/rcp_pkg.sv -----
// ----------------------------------------------------------------------------
// RTMP chunk header parser package
// Shared types and constants for the chunk header parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int unsigned FmtW   = 2;
  localparam int unsigned CsidW  = 17;
  localparam int unsigned TsW    = 32;
  localparam int unsigned SizeW  = 24;
  localparam int unsigned KindW  = 8;
  localparam int unsigned MsidW  = 32;
  localparam int unsigned HlenW  = 5;
  localparam int unsigned OutW   = FmtW + CsidW + TsW + SizeW + KindW + MsidW + HlenW;

  localparam logic [5:0]       IdMask   = 6'h3F;
  localparam logic [TsW-1:0]   TsEscape = 32'h00FF_FFFF;
  localparam logic [CsidW-1:0] IdOffset = 17'd64;
  localparam int unsigned      FmtShift = 6;
  localparam logic [CsidW-1:0] CsidReset = 17'd3;

  localparam logic [FmtW-1:0]  Fmt0 = 2'd0;
  localparam logic [FmtW-1:0]  Fmt1 = 2'd1;
  localparam logic [FmtW-1:0]  Fmt2 = 2'd2;

  localparam logic [5:0] IdOneByte = 6'd0;
  localparam logic [5:0] IdTwoByte = 6'd1;

  typedef enum logic [8:0] {
    PH_BASIC0 = 9'b000000001,
    PH_ONE    = 9'b000000010,
    PH_TWO_LO = 9'b000000100,
    PH_TWO_HI = 9'b000001000,
    PH_TS     = 9'b000010000,
    PH_SIZE   = 9'b000100000,
    PH_KIND   = 9'b001000000,
    PH_MSID   = 9'b010000000,
    PH_EXT    = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [HlenW-1:0] header_bytes;
    logic [MsidW-1:0] message_stream;
    logic [KindW-1:0] message_kind;
    logic [SizeW-1:0] body_length;
    logic [TsW-1:0]   timestamp_value;
    logic [CsidW-1:0] chunk_stream;
    logic [FmtW-1:0]  header_format;
  } result_t;

endpackage

// ----- src/rcp_core.sv -----
// ----------------------------------------------------------------------------
// RTMP chunk header parse core
// Holds the parse state and the shared header context and advances them by
// one header byte per enabled cycle, flagging a completed header.
// ----------------------------------------------------------------------------
module rcp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            restart_i,
  output logic            done_o,
  output rcp_pkg::result_t result_o
);
  import rcp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [2:0]       fbc_q, fbc_d;
  logic [HlenW-1:0] cnt_q, cnt_d;
  logic [31:0]      asm_q, asm_d;
  logic [FmtW-1:0]  fmt_q, fmt_d;
  logic [CsidW-1:0] sid_q, sid_d;
  logic [TsW-1:0]   ts_q, ts_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [MsidW-1:0] msid_q, msid_d;

  logic   do_after, do_check, done;
  phase_e phase_cur;
  logic [2:0]  fbc_inc;
  logic [31:0] asm_shift24;

  always_comb begin
    phase_cur   = restart_i ? PH_BASIC0 : phase_q;
    phase_d     = phase_q;
    fbc_d       = fbc_q;
    cnt_d       = cnt_q + 5'd1;
    asm_d       = asm_q;
    fmt_d       = fmt_q;
    sid_d       = sid_q;
    ts_d        = ts_q;
    size_d      = size_q;
    kind_d      = kind_q;
    msid_d      = msid_q;
    do_after    = 1'b0;
    do_check    = 1'b0;
    done        = 1'b0;
    fbc_inc     = fbc_q + 3'd1;
    asm_shift24 = {8'd0, asm_q[15:0], byte_i};

    unique case (phase_cur)
      PH_ONE: begin
        sid_d    = {9'd0, byte_i} + IdOffset;
        do_after = 1'b1;
      end
      PH_TWO_LO: begin
        sid_d   = {9'd0, byte_i} + IdOffset;
        phase_d = PH_TWO_HI;
        fbc_d   = 3'd0;
        asm_d   = '0;
      end
      PH_TWO_HI: begin
        sid_d    = sid_q + {1'b0, byte_i, 8'd0};
        do_after = 1'b1;
      end
      PH_TS: begin
        asm_d = asm_shift24;
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd3) begin
          ts_d = asm_shift24;
          if (fmt_q <= Fmt1) begin
            phase_d = PH_SIZE;
            fbc_d   = 3'd0;
            asm_d   = '0;
          end else begin
            do_check = 1'b1;
          end
        end
      end
      PH_SIZE: begin
        asm_d = asm_shift24;
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd3) begin
          size_d  = asm_shift24[SizeW-1:0];
          phase_d = PH_KIND;
          fbc_d   = 3'd0;
          asm_d   = '0;
        end
      end
      PH_KIND: begin
        kind_d = byte_i;
        if (fmt_q == Fmt0) begin
          phase_d = PH_MSID;
          fbc_d   = 3'd0;
          asm_d   = '0;
        end else begin
          do_check = 1'b1;
        end
      end
      PH_MSID: begin
        asm_d = asm_q | ({24'd0, byte_i} << {fbc_q[1:0], 3'd0});
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          msid_d   = asm_d;
          do_check = 1'b1;
        end
      end
      PH_EXT: begin
        asm_d = {asm_q[23:0], byte_i};
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          ts_d = asm_d;
          done = 1'b1;
        end
      end
      default: begin
        // First byte of the basic header: format and the short stream id.
        cnt_d = 5'd1;
        fbc_d = 3'd0;
        asm_d = '0;
        fmt_d = byte_i[7:FmtShift];
        sid_d = {11'd0, byte_i[5:0] & IdMask};
        if ((byte_i[5:0] & IdMask) == IdOneByte) begin
          phase_d = PH_ONE;
        end else if ((byte_i[5:0] & IdMask) == IdTwoByte) begin
          phase_d = PH_TWO_LO;
        end else begin
          do_after = 1'b1;
        end
      end
    endcase

    if (do_after) begin
      if (fmt_d <= Fmt2) begin
        phase_d = PH_TS;
        fbc_d   = 3'd0;
        asm_d   = '0;
      end else begin
        do_check = 1'b1;
      end
    end

    // A stored escape value pulls in the extended timestamp.
    if (do_check) begin
      if (ts_d == TsEscape) begin
        phase_d = PH_EXT;
        fbc_d   = 3'd0;
        asm_d   = '0;
      end else begin
        done = 1'b1;
      end
    end

    if (done) begin
      phase_d = PH_BASIC0;
      fbc_d   = 3'd0;
      asm_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BASIC0;
      fbc_q   <= '0;
      cnt_q   <= '0;
      asm_q   <= '0;
      fmt_q   <= '0;
      sid_q   <= CsidReset;
      ts_q    <= '0;
      size_q  <= '0;
      kind_q  <= '0;
      msid_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      cnt_q   <= cnt_d;
      asm_q   <= asm_d;
      fmt_q   <= fmt_d;
      sid_q   <= sid_d;
      ts_q    <= ts_d;
      size_q  <= size_d;
      kind_q  <= kind_d;
      msid_q  <= msid_d;
    end
  end

  assign done_o                   = step_i & done;
  assign result_o.header_format   = fmt_d;
  assign result_o.chunk_stream    = sid_d;
  assign result_o.timestamp_value = ts_d;
  assign result_o.body_length     = size_d;
  assign result_o.message_kind    = kind_d;
  assign result_o.message_stream  = msid_d;
  assign result_o.header_bytes    = cnt_d;

endmodule

// ----- src/rtmp_chunk_header_parser.sv -----
// ----------------------------------------------------------------------------
// RTMP chunk header parser
// Data path: an accepted byte passes from the input register through the parse
// core into the result register. Throughput: one header byte per cycle while
// the result register is free or being drained; otherwise the input stalls.
// Reset: asynchronous, active low; clears the parse state, sets the kept
// chunk stream id to three and empties both registers.
// ----------------------------------------------------------------------------
module rtmp_chunk_header_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // data_byte[7:0]
  input  logic                 s_axis_tuser_i,   // restart[0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // header_format[1:0], chunk_stream[18:2], timestamp_value[50:19],
  // body_length[74:51], message_kind[82:75], message_stream[114:83],
  // header_bytes[119:115]
  output logic [rcp_pkg::OutW-1:0] m_axis_tdata_o
);
  import rcp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_valid_q;
  result_t    out_data_q;
  logic       step;
  logic       done;
  result_t    result;

  // The core steps whenever a word is held and the result slot is free or
  // being drained this cycle.
  assign step            = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | step;

  rcp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .done_o    (done),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
    if (done) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_hlen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.header_bytes != 5'd0 && out_data_q.header_bytes <= 5'd18))
    else $error("header length out of range");

  a_fmt3_short : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.header_format == 2'd3) |-> (out_data_q.header_bytes <= 5'd7))
    else $error("format 3 header too long");

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_restart_q)))
    else $error("held input word lost");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overrun");

endmodule
